>>> hw/rtl/opte_pkg.sv
// Shared types, codes and helpers of the operating point table engine.
// No dependencies; used by both RTL modules and both test files.
`default_nettype none

package opte_pkg;

    // Table geometry.
    localparam int NUM_DOMAINS = 3;
    localparam int MAX_ENTRIES = 16;
    localparam int ENTRIES_ALL = NUM_DOMAINS * MAX_ENTRIES;
    localparam int ADDR_W      = $clog2(ENTRIES_ALL);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIDX_W      = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

    // Field widths.
    localparam int FUNC_W = 4;
    localparam int DOM_W  = 2;
    localparam int RATE_W = 32;
    localparam int VOLT_W = 24;
    localparam int IDX_W  = 4;
    localparam int ID_W   = 5;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;
    localparam int KHZ_W  = 23;
    localparam int POS_W  = 5;

    // Rate divisor for dump items.
    localparam int KHZ_DIV = 1000;
    // Rounded-up 2^38 / KHZ_DIV; its error stays small enough that the scaled
    // product gives the exact quotient for every 32-bit rate.
    localparam logic [RATE_W-1:0] KHZ_RECIP = 32'd274877907;
    localparam int                KHZ_SHIFT = 38;

    // Commands.
    localparam logic [FUNC_W-1:0] F_CLEAR   = 4'd0;
    localparam logic [FUNC_W-1:0] F_APPEND  = 4'd1;
    localparam logic [FUNC_W-1:0] F_INSERT  = 4'd2;
    localparam logic [FUNC_W-1:0] F_EXACT   = 4'd3;
    localparam logic [FUNC_W-1:0] F_CEIL    = 4'd4;
    localparam logic [FUNC_W-1:0] F_FLOOR   = 4'd5;
    localparam logic [FUNC_W-1:0] F_BYID    = 4'd6;
    localparam logic [FUNC_W-1:0] F_COUNT   = 4'd7;
    localparam logic [FUNC_W-1:0] F_ENABLE  = 4'd8;
    localparam logic [FUNC_W-1:0] F_DISABLE = 4'd9;
    localparam logic [FUNC_W-1:0] F_READ    = 4'd10;
    localparam logic [FUNC_W-1:0] F_DUMP    = 4'd11;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // One stored operating point.
    typedef struct packed {
        logic              en;
        logic [VOLT_W-1:0] volt;
        logic [RATE_W-1:0] rate;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic              last;
        logic [POS_W-1:0]  table_position;
        logic [KHZ_W-1:0]  rate_khz;
        logic [ECNT_W-1:0] enabled_count;
        logic [ID_W-1:0]   found_id;
        logic [VOLT_W-1:0] found_voltage_uv;
        logic [RATE_W-1:0] found_rate_hz;
        logic [IDX_W-1:0]  found_index;
        logic [STAT_W-1:0] status;
    } res_t;

    // A final result that carries only a status.
    function automatic res_t res_status(input logic [STAT_W-1:0] st);
        res_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // A final result that reports a matched or read entry.
    function automatic res_t res_hit(input logic [CNT_W-1:0] idx, input entry_t e);
        res_t r;
        r             = res_status(ST_OK);
        r.found_index = idx[IDX_W-1:0];
        r.found_id    = ID_W'(idx) + ID_W'(1);
        if (e.en)
        begin
            r.found_rate_hz    = e.rate;
            r.found_voltage_uv = e.volt;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/opte_khz_div.sv
// Division of a rate by the constant KHZ_DIV through a fixed-point reciprocal.
// Depends on opte_pkg. Registers the operand, then registers the quotient.
`default_nettype none

module opte_khz_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [opte_pkg::RATE_W-1:0] dividend,
    output logic                             busy,
    output logic [opte_pkg::KHZ_W-1:0]       quotient
);
    import opte_pkg::*;

    localparam int PROD_W = KHZ_SHIFT + KHZ_W;

    logic [RATE_W-1:0] dividend_reg;
    logic [KHZ_W-1:0]  quo_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] product;

    // The quotient is the part of the scaled product above the shift point.
    assign product = PROD_W'(dividend_reg) * PROD_W'(KHZ_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    // Capture the operand, then the quotient in the following cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
        end
        if (busy_reg)
        begin
            quo_reg <= product[KHZ_SHIFT +: KHZ_W];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/operating_point_table_engine_unit.sv
// Top level of the operating point table engine: command sequencer and entry memory.
// Depends on opte_pkg and opte_khz_div.
//
// Commands arrive on the s_ group, one transfer per command; results leave on the
// m_ group, tlast marking the final result of a command. A new command is taken
// only after the previous one has placed its last result in the output register.
// All entries sit in one memory with a registered read; every entry visit passes
// through a read state and an evaluate state. Clear, bad or absent-domain commands
// go straight to the output state. Searches and count visit entries one after
// another. Insert visits entries, shifts the ones from the insert point on up by
// one, then writes the new entry. Enable, disable, read and byid visit one entry.
// A dump visits entries from the last down, divides the rate of each enabled one,
// and gives up to 17 results, the last a terminator.
// Reset clears the domain present flags and entry counts; the entry memory holds
// no reset and is read only below the entry count. When the receiver stalls, the
// output register holds its result and the sequencer waits with the next one.
`default_nettype none

module operating_point_table_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: func[3:0], domain[5:4], rate_hz[37:6], voltage_uv[61:38],
    // enabled_flag[62], entry_index[66:63], entry_id[71:67].
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: status[1:0], found_index[5:2], found_rate_hz[37:6],
    // found_voltage_uv[61:38], found_id[66:62], enabled_count[71:67],
    // rate_khz[94:72], table_position[99:95], zero pad[103:100].
    output logic [103:0]     m_tdata,
    output logic             m_tlast
);
    import opte_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_SHR  = 3'd3;
    localparam logic [2:0] S_SHW  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // Input field decode.
    logic [FUNC_W-1:0] in_func;
    logic [DOM_W-1:0]  in_dom;
    logic [RATE_W-1:0] in_rate;
    logic [VOLT_W-1:0] in_volt;
    logic              in_en;
    logic [IDX_W-1:0]  in_idx;
    logic [ID_W-1:0]   in_id;

    assign in_func = s_tdata[3:0];
    assign in_dom  = s_tdata[5:4];
    assign in_rate = s_tdata[37:6];
    assign in_volt = s_tdata[61:38];
    assign in_en   = s_tdata[62];
    assign in_idx  = s_tdata[66:63];
    assign in_id   = s_tdata[71:67];

    // Sequencer registers.
    logic [2:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [DIDX_W-1:0] dom_reg, dom_next;
    logic [RATE_W-1:0] key_reg, key_next;
    logic [VOLT_W-1:0] volt_reg, volt_next;
    logic              want_reg, want_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  hit_idx_reg, hit_idx_next;
    entry_t            hit_ent_reg, hit_ent_next;
    logic              more_reg, more_next;
    res_t              res_reg, res_next;

    // Per-domain bookkeeping.
    logic [CNT_W-1:0]  count_reg [NUM_DOMAINS];
    logic              present_reg [NUM_DOMAINS];
    logic              dom_clear;
    logic              dom_inc;

    // Output register.
    logic              m_valid_reg;
    res_t              m_data_reg;
    logic              out_load;

    // Entry memory ports.
    entry_t            mem [ENTRIES_ALL];
    entry_t            rdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // Divider hookup.
    logic              div_start;
    logic              div_busy;
    logic [KHZ_W-1:0]  div_q;

    // Lookup of the incoming domain's state.
    logic              in_dom_ok;
    logic [DIDX_W-1:0] in_didx;
    logic [CNT_W-1:0]  in_n;
    logic              in_present;
    logic [CNT_W-1:0]  last_idx;
    logic              at_end;
    entry_t            cur_ent;
    entry_t            new_ent;
    res_t              term_res;

    assign in_dom_ok  = (32'(in_dom) < NUM_DOMAINS);
    assign in_didx    = DIDX_W'(in_dom);
    assign in_n       = in_dom_ok ? count_reg[in_didx] : '0;
    assign in_present = in_dom_ok ? present_reg[in_didx] : 1'b0;
    assign last_idx   = n_reg - CNT_W'(1);
    assign at_end     = (ptr_reg == last_idx);
    assign new_ent    = '{en: want_reg, volt: volt_reg, rate: key_reg};

    always_comb
    begin
        term_res                = res_status(ST_OK);
        term_res.table_position = POS_W'(cnt_reg);
    end

    // Memory with one registered read port and one write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata <= mem[mem_raddr];
        end
    end

    opte_khz_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rdata.rate),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Command sequencer.
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        dom_next     = dom_reg;
        key_next     = key_reg;
        volt_next    = volt_reg;
        want_next    = want_reg;
        base_next    = base_reg;
        n_next       = n_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_ent_next = hit_ent_reg;
        more_next    = more_reg;
        res_next     = res_reg;
        dom_clear    = 1'b0;
        dom_inc      = 1'b0;
        out_load     = 1'b0;
        div_start    = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = base_reg + ADDR_W'(ptr_reg);
        mem_we       = 1'b0;
        mem_waddr    = base_reg + ADDR_W'(ptr_reg);
        mem_wdata    = rdata;
        cur_ent      = rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = in_func;
                    dom_next  = in_didx;
                    key_next  = in_rate;
                    volt_next = in_volt;
                    want_next = in_en;
                    base_next = ADDR_W'(32'(in_didx) * MAX_ENTRIES);
                    n_next    = in_n;
                    ptr_next  = '0;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    more_next = 1'b0;
                    state_next = S_OUT;
                    if (!in_dom_ok || in_func > F_DUMP)
                    begin
                        res_next = res_status(ST_INVALID);
                    end
                    else if (in_func == F_CLEAR)
                    begin
                        dom_clear = 1'b1;
                        res_next  = res_status(ST_OK);
                    end
                    else if (!in_present)
                    begin
                        res_next = res_status(ST_NOTFOUND);
                    end
                    else
                    begin
                        case (in_func)
                            F_APPEND, F_INSERT:
                            begin
                                if (32'(in_n) >= MAX_ENTRIES)
                                begin
                                    res_next = res_status(ST_FULL);
                                end
                                else if (in_func == F_APPEND || in_n == '0)
                                begin
                                    pos_next   = in_n;
                                    state_next = S_WR;
                                end
                                else
                                begin
                                    state_next = S_RD;
                                end
                            end
                            F_EXACT, F_CEIL, F_FLOOR, F_COUNT:
                            begin
                                if (in_n != '0)
                                begin
                                    state_next = S_RD;
                                end
                                else if (in_func == F_COUNT)
                                begin
                                    res_next = res_status(ST_OK);
                                end
                                else
                                begin
                                    res_next = res_status(ST_NOTFOUND);
                                end
                            end
                            F_BYID:
                            begin
                                if (in_id == '0)
                                begin
                                    res_next = res_status(ST_INVALID);
                                end
                                else if (ID_W'(in_n) < in_id)
                                begin
                                    res_next = res_status(ST_NOTFOUND);
                                end
                                else
                                begin
                                    ptr_next   = CNT_W'(in_id - ID_W'(1));
                                    state_next = S_RD;
                                end
                            end
                            F_ENABLE, F_DISABLE, F_READ:
                            begin
                                if (CNT_W'(in_idx) >= in_n)
                                begin
                                    res_next = res_status(ST_INVALID);
                                end
                                else
                                begin
                                    ptr_next   = CNT_W'(in_idx);
                                    want_next  = (in_func == F_ENABLE);
                                    state_next = S_RD;
                                end
                            end
                            default:
                            begin
                                // Dump walks down from the last entry.
                                if (in_n == '0)
                                begin
                                    res_next = res_status(ST_OK);
                                end
                                else
                                begin
                                    ptr_next   = in_n;
                                    state_next = S_RD;
                                end
                            end
                        endcase
                    end
                end
            end

            S_RD:
            begin
                mem_re = 1'b1;
                if (func_reg == F_DUMP)
                begin
                    mem_raddr = base_reg + ADDR_W'(ptr_reg - CNT_W'(1));
                end
                state_next = S_EV;
            end

            S_EV:
            begin
                state_next = S_OUT;
                case (func_reg)
                    F_INSERT:
                    begin
                        if (cur_ent.rate >= key_reg)
                        begin
                            pos_next   = ptr_reg;
                            ptr_next   = n_reg;
                            state_next = S_SHR;
                        end
                        else if (at_end)
                        begin
                            pos_next   = n_reg;
                            state_next = S_WR;
                        end
                        else
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    F_EXACT, F_CEIL:
                    begin
                        if ((func_reg == F_EXACT) ?
                            (cur_ent.rate == key_reg && cur_ent.en == want_reg) :
                            (cur_ent.en && cur_ent.rate >= key_reg))
                        begin
                            res_next = res_hit(ptr_reg, cur_ent);
                        end
                        else if (at_end)
                        begin
                            res_next = res_status(ST_NOTFOUND);
                        end
                        else
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    F_FLOOR:
                    begin
                        if (cur_ent.en && cur_ent.rate > key_reg)
                        begin
                            res_next = hit_reg ? res_hit(hit_idx_reg, hit_ent_reg) :
                                                 res_status(ST_NOTFOUND);
                        end
                        else
                        begin
                            if (cur_ent.en)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = ptr_reg;
                                hit_ent_next = cur_ent;
                            end
                            if (at_end)
                            begin
                                res_next = cur_ent.en ? res_hit(ptr_reg, cur_ent) :
                                           (hit_reg ? res_hit(hit_idx_reg, hit_ent_reg) :
                                                      res_status(ST_NOTFOUND));
                            end
                            else
                            begin
                                ptr_next   = ptr_reg + CNT_W'(1);
                                state_next = S_RD;
                            end
                        end
                    end
                    F_COUNT:
                    begin
                        cnt_next = cnt_reg + CNT_W'(cur_ent.en);
                        if (at_end)
                        begin
                            res_next               = res_status(ST_OK);
                            res_next.enabled_count = ECNT_W'(cnt_next);
                        end
                        else
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    F_BYID:
                    begin
                        res_next = cur_ent.en ? res_hit(ptr_reg, cur_ent) :
                                                res_status(ST_NOTFOUND);
                    end
                    F_ENABLE, F_DISABLE:
                    begin
                        // Write the entry back with its new enable bit.
                        mem_we       = 1'b1;
                        mem_wdata.en = want_reg;
                        res_next     = res_status(ST_OK);
                    end
                    F_READ:
                    begin
                        res_next = res_hit(ptr_reg, cur_ent);
                    end
                    default:
                    begin
                        ptr_next = ptr_reg - CNT_W'(1);
                        if (cur_ent.en)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else if (ptr_reg == CNT_W'(1))
                        begin
                            res_next = term_res;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                endcase
            end

            S_SHR:
            begin
                // Fetch the entry below the one being moved into.
                mem_re     = 1'b1;
                mem_raddr  = base_reg + ADDR_W'(ptr_reg - CNT_W'(1));
                state_next = S_SHW;
            end

            S_SHW:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg - CNT_W'(1);
                if (ptr_next > pos_reg)
                begin
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_WR;
                end
            end

            S_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = base_reg + ADDR_W'(pos_reg);
                mem_wdata  = new_ent;
                dom_inc    = 1'b1;
                res_next   = res_status(ST_OK);
                state_next = S_OUT;
            end

            S_DIV:
            begin
                if (!div_busy)
                begin
                    res_next                = '0;
                    res_next.rate_khz       = div_q;
                    res_next.table_position = POS_W'(cnt_reg);
                    cnt_next                = cnt_reg + CNT_W'(1);
                    more_next               = 1'b1;
                    state_next              = S_OUT;
                end
            end

            default:
            begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (!more_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (ptr_reg == '0)
                    begin
                        res_next  = term_res;
                        more_next = 1'b0;
                    end
                    else
                    begin
                        more_next  = 1'b0;
                        state_next = S_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        dom_reg     <= dom_next;
        key_reg     <= key_next;
        volt_reg    <= volt_next;
        want_reg    <= want_next;
        base_reg    <= base_next;
        n_reg       <= n_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        res_reg     <= res_next;
    end

    // Domain present flags and entry counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DOMAINS; i++)
            begin
                count_reg[i]   <= '0;
                present_reg[i] <= 1'b0;
            end
        end
        else if (dom_clear)
        begin
            count_reg[in_didx]   <= '0;
            present_reg[in_didx] <= 1'b1;
        end
        else if (dom_inc)
        begin
            count_reg[dom_reg] <= n_reg + CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= res_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_data_reg.last;
    assign m_tdata  = {4'b0000, m_data_reg.table_position, m_data_reg.rate_khz,
                       m_data_reg.enabled_count, m_data_reg.found_id,
                       m_data_reg.found_voltage_uv, m_data_reg.found_rate_hz,
                       m_data_reg.found_index, m_data_reg.status};

    // The divider only runs inside a dump.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    // The memory is never written between commands.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE))
        else $error("entry memory written while idle");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("command accepted without starting work");

    // A grown table never exceeds its capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        dom_inc |-> (32'(n_reg) < MAX_ENTRIES))
        else $error("entry count grows past capacity");

endmodule

`default_nettype wire

>>> test/opte_checker.sv
// Scoreboard of the operating point table engine: watches both stream channels,
// predicts every result from its own copy of the tables, and compares. Uses opte_pkg.
`timescale 1ns / 1ps

module opte_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [71:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic         m_tlast,
    output int                errors,
    output int                outstanding,
    output int                results_seen,
    output int                dump_items
);
    import opte_pkg::*;

    // Shadow copy of the tables.
    logic [RATE_W-1:0] shadow_rate [ENTRIES_ALL];
    logic [VOLT_W-1:0] shadow_volt [ENTRIES_ALL];
    logic              shadow_en   [ENTRIES_ALL];
    int                shadow_count  [NUM_DOMAINS];
    bit                shadow_present[NUM_DOMAINS];

    res_t pending_results[$];

    initial
    begin
        errors       = 0;
        outstanding  = 0;
        results_seen = 0;
        dump_items   = 0;
        for (int d = 0; d < NUM_DOMAINS; d++)
        begin
            shadow_count[d]   = 0;
            shadow_present[d] = 0;
        end
    end

    function automatic res_t bare_status(input logic [STAT_W-1:0] st);
        res_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic res_t entry_report(input int base, input int pos);
        res_t r;
        r             = bare_status(ST_OK);
        r.found_index = IDX_W'(pos);
        r.found_id    = ID_W'(pos + 1);
        if (shadow_en[base + pos])
        begin
            r.found_rate_hz    = shadow_rate[base + pos];
            r.found_voltage_uv = shadow_volt[base + pos];
        end
        return r;
    endfunction

    // Work out the results of one command and queue them.
    task automatic predict_command(input logic [71:0] cmd);
        logic [FUNC_W-1:0] func;
        logic [DOM_W-1:0]  dom;
        logic [RATE_W-1:0] key;
        logic [VOLT_W-1:0] volt;
        logic              flag;
        logic [IDX_W-1:0]  eidx;
        logic [ID_W-1:0]   eid;
        int   n, base, pos, hit, cnt;
        res_t r;
        func = cmd[3:0];
        dom  = cmd[5:4];
        key  = cmd[37:6];
        volt = cmd[61:38];
        flag = cmd[62];
        eidx = cmd[66:63];
        eid  = cmd[71:67];
        hit  = -1;
        if (dom >= NUM_DOMAINS || func > F_DUMP)
        begin
            pending_results.push_back(bare_status(ST_INVALID));
            return;
        end
        if (func == F_CLEAR)
        begin
            shadow_present[dom] = 1;
            shadow_count[dom]   = 0;
            pending_results.push_back(bare_status(ST_OK));
            return;
        end
        if (!shadow_present[dom])
        begin
            pending_results.push_back(bare_status(ST_NOTFOUND));
            return;
        end
        n    = shadow_count[dom];
        base = dom * MAX_ENTRIES;
        case (func)
            F_APPEND, F_INSERT:
            begin
                if (n >= MAX_ENTRIES)
                begin
                    pending_results.push_back(bare_status(ST_FULL));
                    return;
                end
                pos = n;
                if (func == F_INSERT)
                begin
                    for (int i = 0; i < n; i++)
                        if (shadow_rate[base + i] >= key)
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = n; i > pos; i--)
                    begin
                        shadow_rate[base + i] = shadow_rate[base + i - 1];
                        shadow_volt[base + i] = shadow_volt[base + i - 1];
                        shadow_en[base + i]   = shadow_en[base + i - 1];
                    end
                end
                shadow_rate[base + pos] = key;
                shadow_volt[base + pos] = volt;
                shadow_en[base + pos]   = flag;
                shadow_count[dom]       = n + 1;
                pending_results.push_back(bare_status(ST_OK));
                return;
            end
            F_EXACT:
                for (int i = 0; i < n; i++)
                    if (shadow_rate[base + i] == key && shadow_en[base + i] == flag)
                    begin
                        hit = i;
                        break;
                    end
            F_CEIL:
                for (int i = 0; i < n; i++)
                    if (shadow_en[base + i] && shadow_rate[base + i] >= key)
                    begin
                        hit = i;
                        break;
                    end
            F_FLOOR:
                // The walk stops at the first enabled entry above the key.
                for (int i = 0; i < n; i++)
                    if (shadow_en[base + i])
                    begin
                        if (shadow_rate[base + i] > key)
                            break;
                        hit = i;
                    end
            F_BYID:
            begin
                if (eid == 0)
                begin
                    pending_results.push_back(bare_status(ST_INVALID));
                    return;
                end
                if (eid <= n && shadow_en[base + eid - 1])
                    hit = eid - 1;
            end
            F_COUNT:
            begin
                cnt = 0;
                for (int i = 0; i < n; i++)
                    cnt += shadow_en[base + i];
                r = bare_status(ST_OK);
                r.enabled_count = ECNT_W'(cnt);
                pending_results.push_back(r);
                return;
            end
            F_ENABLE, F_DISABLE, F_READ:
            begin
                if (eidx >= n)
                begin
                    pending_results.push_back(bare_status(ST_INVALID));
                    return;
                end
                if (func == F_ENABLE)
                    shadow_en[base + eidx] = 1'b1;
                else if (func == F_DISABLE)
                    shadow_en[base + eidx] = 1'b0;
                if (func != F_READ)
                begin
                    pending_results.push_back(bare_status(ST_OK));
                    return;
                end
                hit = eidx;
            end
            default:
            begin
                // Table dump: enabled rates from the last entry down, then a terminator.
                cnt = 0;
                for (int i = n - 1; i >= 0; i--)
                    if (shadow_en[base + i])
                    begin
                        r                = '0;
                        r.rate_khz       = KHZ_W'(shadow_rate[base + i] / KHZ_DIV);
                        r.table_position = POS_W'(cnt);
                        pending_results.push_back(r);
                        cnt++;
                    end
                r                = bare_status(ST_OK);
                r.table_position = POS_W'(cnt);
                pending_results.push_back(r);
                dump_items += cnt;
                return;
            end
        endcase
        if (hit < 0)
            pending_results.push_back(bare_status(ST_NOTFOUND));
        else
            pending_results.push_back(entry_report(base, hit));
    endtask

    // Sample both channels at the clock edge; each transfer is handled here once.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_command(s_tdata);
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = res_t'({m_tlast, m_tdata[99:0]});
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing expected: %h last %b",
                                 $realtime, m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want || m_tlast !== want.last || m_tdata[103:100] !== 4'd0)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected st %0d ix %0d hz %h uv %h id %0d",
                                     want.status, want.found_index, want.found_rate_hz,
                                     want.found_voltage_uv, want.found_id);
                            $display("           n %0d khz %0d pos %0d last %b",
                                     want.enabled_count, want.rate_khz,
                                     want.table_position, want.last);
                            $display("  actual   st %0d ix %0d hz %h uv %h id %0d",
                                     got.status, got.found_index, got.found_rate_hz,
                                     got.found_voltage_uv, got.found_id);
                            $display("           n %0d khz %0d pos %0d last %b pad %h",
                                     got.enabled_count, got.rate_khz,
                                     got.table_position, m_tlast, m_tdata[103:100]);
                        end
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

>>> test/testbench.sv
// Top of the operating point table engine regression: clock, reset, command
// stimulus, receiver stalls, watchdog and verdict. Uses opte_pkg and opte_checker.
`timescale 1ns / 1ps

module testbench;
    import opte_pkg::*;

    localparam logic [FUNC_W-1:0] F_UNUSED_LO = 4'd12;
    localparam logic [FUNC_W-1:0] F_UNUSED_HI = 4'd15;
    localparam logic [DOM_W-1:0]  DOM_BAD     = 2'd3;
    localparam int RANDOM_ITEMS = 330;
    localparam int IDLE_LIMIT   = 6000;
    localparam int HOLD_CYCLES  = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;

    int  errors, outstanding, results_seen, dump_items;
    int  commands_sent = 0;
    int  idle_cycles = 0;
    bit  rx_calm = 0;
    bit  tx_calm = 0;
    bit  hold_req = 0;
    logic [RATE_W-1:0] rate_pool [8];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    operating_point_table_engine_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    opte_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .dump_items   (dump_items)
    );

    // Watchdog: ends the run after a long stretch without any transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("operating_point_table_engine_unit regression: fail");
            $finish;
        end
    end

    // Receiver: mostly ready, short and long stalls, and one long hold-off on request.
    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
                m_tready <= 1'b1;
            end
            else if (rx_calm)
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    m_tready <= 1'b1;
                else if (r < 97)
                    m_tready <= 1'b0;
                else
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command and wait for its transfer.
    task automatic send_command(input logic [FUNC_W-1:0] func, input logic [DOM_W-1:0] dom,
                                input logic [RATE_W-1:0] rate, input logic [VOLT_W-1:0] volt,
                                input logic flag, input logic [IDX_W-1:0] eidx,
                                input logic [ID_W-1:0] eid);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {eid, eidx, flag, volt, rate, dom, func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        commands_sent++;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return rate_pool[$urandom_range(0, 7)];
        if (r < 75)
            return rate_pool[$urandom_range(0, 7)] + RATE_W'($urandom_range(0, 2)) - RATE_W'(1);
        return $urandom;
    endfunction

    function automatic logic [DOM_W-1:0] pick_domain();
        if ($urandom_range(0, 99) < 5)
            return DOM_BAD;
        return DOM_W'($urandom_range(0, NUM_DOMAINS - 1));
    endfunction

    // One random command, weighted toward building and searching tables.
    task automatic send_random_command();
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  eidx;
        logic [ID_W-1:0]   eid;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)       func = F_CLEAR;
        else if (r < 18) func = F_APPEND;
        else if (r < 36) func = F_INSERT;
        else if (r < 44) func = F_EXACT;
        else if (r < 52) func = F_CEIL;
        else if (r < 60) func = F_FLOOR;
        else if (r < 67) func = F_BYID;
        else if (r < 71) func = F_COUNT;
        else if (r < 77) func = F_ENABLE;
        else if (r < 83) func = F_DISABLE;
        else if (r < 90) func = F_READ;
        else if (r < 97) func = F_DUMP;
        else             func = FUNC_W'($urandom_range(F_UNUSED_LO, F_UNUSED_HI));
        eidx = ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        eid  = ($urandom_range(0, 9) != 0) ? ID_W'($urandom_range(0, 17)) : ID_W'($urandom);
        send_command(func, pick_domain(), pick_rate(), VOLT_W'($urandom),
                     1'($urandom_range(0, 3) != 0), eidx, eid);
    endtask

    initial
    begin
        logic [DOM_W-1:0] fill_dom;
        for (int i = 0; i < 8; i++)
            rate_pool[i] = $urandom;
        rate_pool[0] = '0;
        rate_pool[1] = '1;
        rate_pool[2] = 32'd999;
        rate_pool[3] = 32'd1000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: absent and bad domains, unknown command, then one of each command.
        send_command(F_DUMP,    2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_READ,    2'd1,    '0, '0, 1'b0, '0, '0);
        send_command(F_CLEAR,   DOM_BAD, '0, '0, 1'b0, '0, '0);
        send_command(F_UNUSED_HI, 2'd0,  '1, '1, 1'b1, '1, '1);
        send_command(F_CLEAR,   2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_DUMP,    2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_FLOOR,   2'd0,    '1, '0, 1'b1, '0, '0);
        send_command(F_APPEND,  2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_APPEND,  2'd0,    '1, '1, 1'b1, '0, '0);
        send_command(F_INSERT,  2'd0,    32'd5000, 24'd900000, 1'b1, '0, '0);
        send_command(F_INSERT,  2'd0,    32'd5000, 24'd800000, 1'b1, '0, '0);
        send_command(F_EXACT,   2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_EXACT,   2'd0,    '0, '0, 1'b1, '0, '0);
        send_command(F_CEIL,    2'd0,    32'd1, '0, 1'b0, '0, '0);
        send_command(F_FLOOR,   2'd0,    32'd4999, '0, 1'b0, '0, '0);
        send_command(F_FLOOR,   2'd0,    '1, '0, 1'b0, '0, '0);
        send_command(F_BYID,    2'd0,    '0, '0, 1'b0, '0, 5'd0);
        send_command(F_BYID,    2'd0,    '0, '0, 1'b0, '0, 5'd1);
        send_command(F_BYID,    2'd0,    '0, '0, 1'b0, '0, 5'd2);
        send_command(F_ENABLE,  2'd0,    '0, '0, 1'b0, 4'd0, '0);
        send_command(F_DISABLE, 2'd0,    '0, '0, 1'b0, 4'd3, '0);
        send_command(F_READ,    2'd0,    '0, '0, 1'b0, 4'd3, '0);
        send_command(F_READ,    2'd0,    '0, '0, 1'b0, 4'd15, '0);
        send_command(F_COUNT,   2'd0,    '0, '0, 1'b0, '0, '0);
        send_command(F_DUMP,    2'd0,    '0, '0, 1'b0, '0, '0);

        // Make every domain present before the random traffic.
        send_command(F_CLEAR, 2'd1, '0, '0, 1'b0, '0, '0);
        send_command(F_CLEAR, 2'd2, '0, '0, 1'b0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Now and then fill one table past full.
            if (n % 100 == 50)
            begin
                fill_dom = DOM_W'($urandom_range(0, NUM_DOMAINS - 1));
                send_command(F_CLEAR, fill_dom, '0, '0, 1'b0, '0, '0);
                for (int k = 0; k <= MAX_ENTRIES; k++)
                    send_command(($urandom_range(0, 1) != 0) ? F_INSERT : F_APPEND, fill_dom,
                                 pick_rate(), VOLT_W'($urandom), 1'($urandom_range(0, 3) != 0),
                                 '0, '0);
                send_command(F_DUMP, fill_dom, '0, '0, 1'b0, '0, '0);
            end
            if (n == 120)
                hold_req = 1;
            tx_calm = (n >= 200 && n < 260);
            rx_calm = tx_calm;
            send_random_command();
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the slowest command to settle.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);

        $display("Sent %0d commands, checked %0d results including %0d dump rates.",
                 commands_sent, results_seen, dump_items);
        if (errors == 0 && outstanding == 0)
            $display("operating_point_table_engine_unit regression: pass");
        else
            $display("operating_point_table_engine_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/opte_pkg.sv
hw/rtl/opte_khz_div.sv
hw/rtl/operating_point_table_engine_unit.sv
test/opte_checker.sv
test/testbench.sv
